// File: src/pcst_pkg.sv
// Package for the pulse-count sound trigger.
// Holds the sequencer phase type, register indexes and register reset values.
// No dependencies.
`default_nettype none
package pcst_pkg;

  localparam int unsigned TimerW = 20;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_RST_HIGH  = 6'b000010,
    PH_RST_LOW   = 6'b000100,
    PH_DATA_HIGH = 6'b001000,
    PH_DATA_LOW  = 6'b010000,
    PH_GAP       = 6'b100000
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_HIGH = 3'd0,
    REG_RESET_LOW  = 3'd1,
    REG_PULSE_HIGH = 3'd2,
    REG_PULSE_LOW  = 3'd3,
    REG_GAP        = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] RESET_HIGH_DEF = 16'd660;
  localparam logic [15:0] RESET_LOW_DEF  = 16'd660;
  localparam logic [15:0] PULSE_HIGH_DEF = 16'd330;
  localparam logic [15:0] PULSE_LOW_DEF  = 16'd330;
  localparam logic [19:0] GAP_DEF        = 20'd200000;

endpackage
`default_nettype wire

// File: src/pulse_count_sound_trigger_top.sv
// Top level of the pulse-count sound trigger: sequencer and result register.
// Depends on pcst_pkg.
//
// Usage: the input channel carries one item per transfer, either a tick
// (command 0, which advances the sequencer by one time unit and samples the
// chip's ready line) or a play request (command 1, which loads the pulse
// count and repeat count and cancels any sequence in progress). Every input
// transfer yields exactly one result transfer that shows the line levels,
// the sending and waiting flags and the repetitions left after that item.
// The result is registered and valid in the cycle after the input transfer;
// with a single result register, one item is taken in every cycle unless
// the receiver stalls. The input is stalled only while a result is
// held and the receiver stalls, so nothing is lost or repeated.
// The configuration port writes the duration registers, counted in ticks;
// the user must use it only while the block is idle, which the block does
// not enforce. Reset returns the sequencer to idle with zero counts, loads
// the default durations and empties the result register.
`default_nettype none
module pulse_count_sound_trigger_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pcst_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pcst_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic [pcst_pkg::CountW-1:0]   in_pulse_count,
  input  wire logic [pcst_pkg::CountW-1:0]   in_repeat_count,
  input  wire logic                          in_chip_ready,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_data_line,
  output logic                               out_reset_line,
  output logic                               out_sending,
  output logic                               out_waiting_ready,
  output logic [pcst_pkg::CountW-1:0]        out_repeats_left
);
  import pcst_pkg::*;

  logic [15:0]       reset_high_r, reset_low_r, pulse_high_r, pulse_low_r;
  logic [TimerW-1:0] gap_r;

  phase_t            phase_r, phase_nxt;
  logic [TimerW-1:0] timer_r, timer_nxt;
  logic [CountW-1:0] pulses_left_r, pulses_left_nxt;
  logic [CountW-1:0] pulse_total_r, pulse_total_nxt;
  logic [CountW-1:0] repeat_total_r, repeat_total_nxt;

  logic              out_valid_r;
  logic              data_line_r, reset_line_r, sending_r, waiting_r;
  logic [CountW-1:0] repeats_left_r;

  logic              accept;
  logic              waiting;
  logic [CountW-1:0] pl_dec;
  logic [CountW-1:0] data_cnt;
  logic [TimerW-1:0] reset_high_t, reset_low_t, pulse_high_t, pulse_low_t;

  function automatic logic [TimerW-1:0] at_least_one(input logic [15:0] v);
    logic [TimerW-1:0] w;
    w = {{(TimerW-16){1'b0}}, v};
    return (v == 16'd0) ? TimerW'(1) : w;
  endfunction

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign reset_high_t = at_least_one(reset_high_r);
  assign reset_low_t  = at_least_one(reset_low_r);
  assign pulse_high_t = at_least_one(pulse_high_r);
  assign pulse_low_t  = at_least_one(pulse_low_r);
  assign pl_dec   = (pulses_left_r != '0) ? pulses_left_r - CountW'(1) : '0;
  assign data_cnt = (phase_r == PH_DATA_LOW) ? pl_dec : pulses_left_r;

  always_comb begin
    phase_nxt        = phase_r;
    timer_nxt        = timer_r;
    pulses_left_nxt  = pulses_left_r;
    pulse_total_nxt  = pulse_total_r;
    repeat_total_nxt = repeat_total_r;
    waiting          = 1'b0;
    if (in_command) begin
      pulse_total_nxt  = in_pulse_count;
      repeat_total_nxt = in_repeat_count;
      pulses_left_nxt  = '0;
      phase_nxt        = PH_IDLE;
      timer_nxt        = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (repeat_total_r != '0) begin
            if (in_chip_ready) begin
              phase_nxt       = PH_RST_HIGH;
              timer_nxt       = reset_high_t;
              pulses_left_nxt = pulse_total_r;
            end else begin
              waiting = 1'b1;
            end
          end
        end
        default: begin
          if (timer_r <= TimerW'(1)) begin
            timer_nxt = '0;
            unique case (phase_r)
              PH_RST_HIGH: begin
                phase_nxt = PH_RST_LOW;
                timer_nxt = reset_low_t;
              end
              PH_DATA_HIGH: begin
                phase_nxt = PH_DATA_LOW;
                timer_nxt = pulse_low_t;
              end
              PH_RST_LOW, PH_DATA_LOW: begin
                pulses_left_nxt = data_cnt;
                if (data_cnt != '0) begin
                  phase_nxt = PH_DATA_HIGH;
                  timer_nxt = pulse_high_t;
                end else if (gap_r != '0) begin
                  phase_nxt = PH_GAP;
                  timer_nxt = gap_r;
                end else begin
                  if (repeat_total_r != '0) begin
                    repeat_total_nxt = repeat_total_r - CountW'(1);
                  end
                  phase_nxt = PH_IDLE;
                end
              end
              default: begin
                if (repeat_total_r != '0) begin
                  repeat_total_nxt = repeat_total_r - CountW'(1);
                end
                phase_nxt = PH_IDLE;
              end
            endcase
          end else begin
            timer_nxt = timer_r - TimerW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_high_r <= RESET_HIGH_DEF;
      reset_low_r  <= RESET_LOW_DEF;
      pulse_high_r <= PULSE_HIGH_DEF;
      pulse_low_r  <= PULSE_LOW_DEF;
      gap_r        <= GAP_DEF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RESET_HIGH: reset_high_r <= cfg_data[15:0];
        REG_RESET_LOW:  reset_low_r  <= cfg_data[15:0];
        REG_PULSE_HIGH: pulse_high_r <= cfg_data[15:0];
        REG_PULSE_LOW:  pulse_low_r  <= cfg_data[15:0];
        REG_GAP:        gap_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      timer_r        <= '0;
      pulses_left_r  <= '0;
      pulse_total_r  <= '0;
      repeat_total_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        phase_r        <= phase_nxt;
        timer_r        <= timer_nxt;
        pulses_left_r  <= pulses_left_nxt;
        pulse_total_r  <= pulse_total_nxt;
        repeat_total_r <= repeat_total_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_line_r    <= (phase_nxt == PH_DATA_HIGH);
      reset_line_r   <= (phase_nxt == PH_RST_HIGH);
      sending_r      <= (repeat_total_nxt != '0);
      waiting_r      <= waiting;
      repeats_left_r <= repeat_total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_line     = data_line_r;
  assign out_reset_line    = reset_line_r;
  assign out_sending       = sending_r;
  assign out_waiting_ready = waiting_r;
  assign out_repeats_left  = repeats_left_r;

endmodule
`default_nettype wire

// File: dv/pulse_count_sound_trigger_top_tb.sv
// Testbench for pulse_count_sound_trigger_top: random valid/stall traffic on both channels,
// with line states predicted per transfer and compared in order against the block's results.
// Depends on pcst_pkg and the pulse_count_sound_trigger_top RTL.
`timescale 1ns / 1ps
module pulse_count_sound_trigger_top_tb;
  import pcst_pkg::*;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PLAY = 1'b1;
  localparam logic [CfgIdxW-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic              command;
    logic [CountW-1:0] pulse_count;
    logic [CountW-1:0] repeat_count;
    logic              chip_ready;
  } trig_item_t;

  typedef struct packed {
    logic              data_line;
    logic              reset_line;
    logic              sending;
    logic              waiting_ready;
    logic [CountW-1:0] repeats_left;
  } line_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_RESET_HIGH;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_TICK;
  logic [CountW-1:0] in_pulse_count = '0;
  logic [CountW-1:0] in_repeat_count = '0;
  logic in_chip_ready = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_data_line;
  logic out_reset_line;
  logic out_sending;
  logic out_waiting_ready;
  logic [CountW-1:0] out_repeats_left;

  pulse_count_sound_trigger_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_pulse_count    (in_pulse_count),
    .in_repeat_count   (in_repeat_count),
    .in_chip_ready     (in_chip_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_line     (out_data_line),
    .out_reset_line    (out_reset_line),
    .out_sending       (out_sending),
    .out_waiting_ready (out_waiting_ready),
    .out_repeats_left  (out_repeats_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trig_item_t  pending_items[$];
  line_state_t expected_lines[$];
  int unsigned items_issued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;

  logic [15:0] rst_high_ticks;
  logic [15:0] rst_low_ticks;
  logic [15:0] pulse_high_ticks;
  logic [15:0] pulse_low_ticks;
  logic [TimerW-1:0] gap_len;
  phase_t seq_phase;
  logic [TimerW-1:0] phase_timer;
  logic [CountW-1:0] pulses_left;
  logic [CountW-1:0] pulse_total;
  logic [CountW-1:0] repeat_total;

  function automatic logic [TimerW-1:0] ticks_or_one(logic [15:0] ticks);
    return (ticks == 16'd0) ? TimerW'(1) : TimerW'(ticks);
  endfunction

  function automatic int unsigned idle_draw(bit steady);
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic line_state_t sequencer_step(trig_item_t item);
    line_state_t lines;
    logic waiting;
    logic rep_done;
    waiting = 1'b0;
    rep_done = 1'b0;
    if (item.command == CMD_PLAY) begin
      pulse_total = item.pulse_count;
      repeat_total = item.repeat_count;
      pulses_left = '0;
      seq_phase = PH_IDLE;
      phase_timer = '0;
    end else if (seq_phase == PH_IDLE) begin
      if (repeat_total != '0) begin
        if (item.chip_ready) begin
          seq_phase = PH_RST_HIGH;
          phase_timer = ticks_or_one(rst_high_ticks);
          pulses_left = pulse_total;
        end else begin
          waiting = 1'b1;
        end
      end
    end else if (phase_timer > TimerW'(1)) begin
      phase_timer = phase_timer - 1'b1;
    end else begin
      phase_timer = '0;
      case (seq_phase)
        PH_RST_HIGH: begin
          seq_phase = PH_RST_LOW;
          phase_timer = ticks_or_one(rst_low_ticks);
        end
        PH_DATA_HIGH: begin
          seq_phase = PH_DATA_LOW;
          phase_timer = ticks_or_one(pulse_low_ticks);
        end
        PH_RST_LOW, PH_DATA_LOW: begin
          if (seq_phase == PH_DATA_LOW && pulses_left != '0) pulses_left = pulses_left - 1'b1;
          if (pulses_left != '0) begin
            seq_phase = PH_DATA_HIGH;
            phase_timer = ticks_or_one(pulse_high_ticks);
          end else if (gap_len != '0) begin
            seq_phase = PH_GAP;
            phase_timer = gap_len;
          end else begin
            rep_done = 1'b1;
          end
        end
        default: rep_done = 1'b1;
      endcase
      if (rep_done) begin
        if (repeat_total != '0) repeat_total = repeat_total - 1'b1;
        seq_phase = PH_IDLE;
        phase_timer = '0;
      end
    end
    lines.data_line = (seq_phase == PH_DATA_HIGH);
    lines.reset_line = (seq_phase == PH_RST_HIGH);
    lines.sending = (repeat_total != '0);
    lines.waiting_ready = waiting;
    lines.repeats_left = repeat_total;
    return lines;
  endfunction

  always @(posedge clk) begin : scoreboard
    line_state_t got;
    line_state_t want;
    in_xfer <= rst_n && in_valid && !in_stall;
    out_xfer <= rst_n && out_valid && !out_stall;
    if (!rst_n) begin
      rst_high_ticks = RESET_HIGH_DEF;
      rst_low_ticks = RESET_LOW_DEF;
      pulse_high_ticks = PULSE_HIGH_DEF;
      pulse_low_ticks = PULSE_LOW_DEF;
      gap_len = GAP_DEF;
      seq_phase = PH_IDLE;
      phase_timer = '0;
      pulses_left = '0;
      pulse_total = '0;
      repeat_total = '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RESET_HIGH: rst_high_ticks = cfg_data[15:0];
          REG_RESET_LOW:  rst_low_ticks = cfg_data[15:0];
          REG_PULSE_HIGH: pulse_high_ticks = cfg_data[15:0];
          REG_PULSE_LOW:  pulse_low_ticks = cfg_data[15:0];
          REG_GAP:        gap_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_lines.push_back(
          sequencer_step({in_command, in_pulse_count, in_repeat_count, in_chip_ready}));
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        got = {out_data_line, out_reset_line, out_sending, out_waiting_ready, out_repeats_left};
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = expected_lines.pop_front();
          if (got.data_line !== want.data_line || got.reset_line !== want.reset_line ||
              got.sending !== want.sending || got.waiting_ready !== want.waiting_ready ||
              got.repeats_left !== want.repeats_left) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch: expected %p", results_seen, want);
              $display("result %0d mismatch: actual   %p", results_seen, got);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    trig_item_t item;
    int unsigned gap_left;
    bit steady;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      steady = 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() != 0) begin
        item = pending_items.pop_front();
        in_command <= item.command;
        in_pulse_count <= item.pulse_count;
        in_repeat_count <= item.repeat_count;
        in_chip_ready <= item.chip_ready;
        in_valid <= 1'b1;
        if ($urandom_range(0, 31) == 0) steady = !steady;
        gap_left = idle_draw(steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    int unsigned wait_left;
    bit steady;
    if (!rst_n) begin
      wait_left = 0;
      steady = 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (out_xfer) begin
        if ($urandom_range(0, 31) == 0) steady = !steady;
        wait_left = idle_draw(steady);
      end
      out_stall <= (wait_left != 0);
      if (wait_left != 0) wait_left--;
    end
  end

  task automatic queue_tick(logic ready);
    pending_items.push_back({CMD_TICK, 8'($urandom), 8'($urandom), ready});
    items_issued++;
  endtask

  task automatic queue_play(logic [CountW-1:0] pulses, logic [CountW-1:0] repeats);
    pending_items.push_back({CMD_PLAY, pulses, repeats, 1'($urandom)});
    items_issued++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (results_seen < items_issued);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned stop_at;
    int unsigned ticks;
    stop_at = items_issued + count;
    while (items_issued < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_play(8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 3)) queue_tick(1'($urandom));
      end else begin
        queue_play(8'($urandom_range(0, 4)), 8'($urandom_range(1, 3)));
        ticks = $urandom_range(5, 50);
        repeat (ticks) queue_tick($urandom_range(0, 7) != 0);
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default durations: idle ticks, zero repeats, waiting on ready, cancel.
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_play(8'd0, 8'd0);
    queue_tick(1'b1);
    queue_play(8'd255, 8'd255);
    queue_tick(1'b0);
    queue_tick(1'b0);
    repeat (3) queue_tick(1'b1);
    queue_play(8'hAA, 8'h55);
    drain();

    // Zero widths act as one tick and a zero gap ends the repetition at once.
    write_reg(REG_RESET_HIGH, '0);
    write_reg(REG_RESET_LOW, '0);
    write_reg(REG_PULSE_HIGH, '0);
    write_reg(REG_PULSE_LOW, '0);
    write_reg(REG_GAP, '0);
    queue_play(8'd0, 8'd1);
    repeat (3) queue_tick(1'b1);
    queue_play(8'd1, 8'd2);
    repeat (8) queue_tick(1'b1);
    drain();

    write_reg(REG_RESET_HIGH, 20'hFFFFF);
    write_reg(REG_RESET_LOW, 20'hFFFFF);
    write_reg(REG_PULSE_HIGH, 20'hFFFFF);
    write_reg(REG_PULSE_LOW, 20'hFFFFF);
    write_reg(REG_GAP, 20'hFFFFF);
    write_reg(REG_NONE, 20'h00001);
    random_traffic(40);
    drain();

    repeat (6) begin
      write_reg(REG_RESET_HIGH, {4'($urandom), 16'($urandom_range(0, 3))});
      write_reg(REG_RESET_LOW, {4'($urandom), 16'($urandom_range(0, 3))});
      write_reg(REG_PULSE_HIGH, {4'($urandom), 16'($urandom_range(0, 3))});
      write_reg(REG_PULSE_LOW, {4'($urandom), 16'($urandom_range(0, 3))});
      write_reg(REG_GAP, 20'($urandom_range(0, 8)));
      random_traffic(75);
      drain();
    end

    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
src/pcst_pkg.sv
src/pulse_count_sound_trigger_top.sv
dv/pulse_count_sound_trigger_top_tb.sv
